/* hdl/esc_pkg.sv */
// Package for the environmental sensor compensation block.
// Holds register indexes, field widths, the pipeline sideband type and helpers.
// Used by every module under hdl; it depends on nothing else.
package esc_pkg;

    localparam int unsigned RegCount  = 6;
    localparam int unsigned AddrWidth = 6;
    localparam int unsigned DivSteps  = 64;

    typedef enum logic [2:0] {
        REG_TEMP_TRIM    = 3'd0,
        REG_PRESS_TRIM_A = 3'd1,
        REG_PRESS_TRIM_B = 3'd2,
        REG_PRESS_TRIM_C = 3'd3,
        REG_HUM_TRIM_A   = 3'd4,
        REG_HUM_TRIM_B   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [47:0] temp;
        logic [47:0] press_a;
        logic [47:0] press_b;
        logic [47:0] press_c;
        logic [31:0] hum_a;
        logic [31:0] hum_b;
    } t_trim;

    // Result of the non-divider part, carried alongside the divider.
    typedef struct packed {
        logic signed [31:0] temp;
        logic signed [31:0] fine;
        logic [16:0]        hum;
        logic               zero_div;
    } t_side;

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned s);
        logic signed [31:0] t;
        t = signed'(x);
        return 32'(t >>> s);
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned s);
        logic signed [63:0] t;
        t = signed'(x);
        return 64'(t >>> s);
    endfunction

endpackage

/* hdl/esc_regs.sv */
// APB-style register file holding the calibration trim words.
// Depends on esc_pkg.
module esc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [esc_pkg::AddrWidth-1:0] paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    output esc_pkg::t_trim                o_trim
);
    import esc_pkg::*;

    t_trim    r_trim;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[AddrWidth-1:3]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_trim = r_trim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_TEMP_TRIM:    r_trim.temp    <= pwdata[47:0];
                REG_PRESS_TRIM_A: r_trim.press_a <= pwdata[47:0];
                REG_PRESS_TRIM_B: r_trim.press_b <= pwdata[47:0];
                REG_PRESS_TRIM_C: r_trim.press_c <= pwdata[47:0];
                REG_HUM_TRIM_A:   r_trim.hum_a   <= pwdata[31:0];
                REG_HUM_TRIM_B:   r_trim.hum_b   <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TEMP_TRIM:    prdata = {16'd0, r_trim.temp};
            REG_PRESS_TRIM_A: prdata = {16'd0, r_trim.press_a};
            REG_PRESS_TRIM_B: prdata = {16'd0, r_trim.press_b};
            REG_PRESS_TRIM_C: prdata = {16'd0, r_trim.press_c};
            REG_HUM_TRIM_A:   prdata = {32'd0, r_trim.hum_a};
            REG_HUM_TRIM_B:   prdata = {32'd0, r_trim.hum_b};
            default:          prdata = '0;
        endcase
    end
endmodule

/* hdl/esc_front.sv */
// Front pipeline: temperature, humidity and the pressure numerator and divisor.
// Depends on esc_pkg. Nine register stages, each with a valid bit and stall enable.
module esc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [19:0]           i_raw_t,
    input  logic [19:0]           i_raw_p,
    input  logic [15:0]           i_raw_h,
    input  esc_pkg::t_trim        i_trim,
    output logic                  o_valid,
    output esc_pkg::t_side        o_side,
    output logic [63:0]           o_num,
    output logic [63:0]           o_den,
    output logic signed [15:0]    o_p9,
    output logic signed [15:0]    o_p8,
    output logic signed [15:0]    o_p7
);
    import esc_pkg::*;

    localparam int unsigned Stages = 9;

    logic [Stages-1:0] r_vld;

    logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6;

    assign t1 = {16'd0, i_trim.temp[15:0]};
    assign t2 = 32'(signed'(i_trim.temp[31:16]));
    assign t3 = 32'(signed'(i_trim.temp[47:32]));
    assign p1 = i_trim.press_a[15:0];
    assign p2 = signed'(i_trim.press_a[31:16]);
    assign p3 = signed'(i_trim.press_a[47:32]);
    assign p4 = signed'(i_trim.press_b[15:0]);
    assign p5 = signed'(i_trim.press_b[31:16]);
    assign p6 = signed'(i_trim.press_b[47:32]);
    assign o_p7 = signed'(i_trim.press_c[15:0]);
    assign o_p8 = signed'(i_trim.press_c[31:16]);
    assign o_p9 = signed'(i_trim.press_c[47:32]);
    assign h1 = {24'd0, i_trim.hum_a[7:0]};
    assign h2 = 32'(signed'(i_trim.hum_a[23:8]));
    assign h3 = {24'd0, i_trim.hum_a[31:24]};
    assign h4 = 32'(signed'(i_trim.hum_b[11:0]));
    assign h5 = 32'(signed'(i_trim.hum_b[23:12]));
    assign h6 = 32'(signed'(i_trim.hum_b[31:24]));

    // Stage 1: temperature products.
    logic [31:0] r1_tv1m, r1_dd;
    logic [19:0] r1_rp;
    logic [15:0] r1_rh;
    // Stage 2.
    logic [31:0] r2_tv1, r2_ddt;
    logic [19:0] r2_rp;
    logic [15:0] r2_rh;
    // Stage 3: fine temperature.
    logic [31:0] r3_tf;
    logic [19:0] r3_rp;
    logic [15:0] r3_rh;
    // Stage 4: first order products.
    logic [31:0] r4_tf, r4_t5, r4_h5v, r4_vh6, r4_vh3;
    logic [63:0] r4_v1sq, r4_v1p5, r4_v1p2;
    logic [19:0] r4_rp;
    logic [15:0] r4_rh;
    // Stage 5.
    logic [31:0] r5_tf, r5_temp, r5_x, r5_y;
    logic [63:0] r5_v2, r5_sqp3, r5_v1p2;
    logic [19:0] r5_rp;
    // Stage 6.
    logic [31:0] r6_tf, r6_temp, r6_x, r6_y;
    logic [63:0] r6_v2, r6_v1;
    logic [19:0] r6_rp;
    // Stage 7.
    logic [31:0] r7_tf, r7_temp, r7_v;
    logic [63:0] r7_v2, r7_v1p1;
    logic [19:0] r7_rp;
    // Stage 8.
    logic [31:0] r8_tf, r8_temp, r8_v, r8_ss;
    logic [63:0] r8_den, r8_numa;
    // Stage 9.
    logic [31:0] r9_tf, r9_temp;
    logic [16:0] r9_hum;
    logic [63:0] r9_den, r9_num;

    logic [31:0] n8_h, n9_v;

    logic signed [32:0] w_v1;
    logic signed [65:0] w_v1sq;
    logic signed [48:0] w_v1p5, w_v1p2;
    logic signed [63:0] w_sqp6, w_sqp3;

    assign w_v1   = 33'(signed'(r3_tf)) - 33'sd128000;
    assign w_v1sq = w_v1 * w_v1;
    assign w_v1p5 = w_v1 * p5;
    assign w_v1p2 = w_v1 * p2;
    assign w_sqp6 = signed'(r4_v1sq) * p6;
    assign w_sqp3 = signed'(r4_v1sq) * p3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Stages-2:0], i_valid};
        end
    end

    always_comb begin
        n8_h = asr32(asr32(r7_v, 15) * asr32(r7_v, 15), 7);
        n9_v = r8_v - asr32(r8_ss * h1, 4);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_tv1m <= ({15'd0, i_raw_t[19:3]} - (t1 << 1)) * t2;
            r1_dd   <= ({16'd0, i_raw_t[19:4]} - t1) * ({16'd0, i_raw_t[19:4]} - t1);
            r1_rp   <= i_raw_p;
            r1_rh   <= i_raw_h;

            r2_tv1 <= asr32(r1_tv1m, 11);
            r2_ddt <= asr32(r1_dd, 12) * t3;
            r2_rp  <= r1_rp;
            r2_rh  <= r1_rh;

            r3_tf <= r2_tv1 + asr32(r2_ddt, 14);
            r3_rp <= r2_rp;
            r3_rh <= r2_rh;

            r4_tf   <= r3_tf;
            r4_t5   <= r3_tf * 32'd5 + 32'd128;
            r4_h5v  <= h5 * (r3_tf - 32'd76800);
            r4_vh6  <= (r3_tf - 32'd76800) * h6;
            r4_vh3  <= (r3_tf - 32'd76800) * h3;
            r4_v1sq <= w_v1sq[63:0];
            r4_v1p5 <= 64'(w_v1p5);
            r4_v1p2 <= 64'(w_v1p2);
            r4_rp   <= r3_rp;
            r4_rh   <= r3_rh;

            r5_tf   <= r4_tf;
            r5_temp <= asr32(r4_t5, 8);
            r5_x    <= asr32(({16'd0, r4_rh} << 14) - (h4 << 20) - r4_h5v + 32'd16384, 15);
            r5_y    <= asr32(r4_vh6, 10) * (asr32(r4_vh3, 11) + 32'd32768);
            r5_v2   <= w_sqp6 + (r4_v1p5 << 17) + (64'(p4) << 35);
            r5_sqp3 <= w_sqp3;
            r5_v1p2 <= r4_v1p2;
            r5_rp   <= r4_rp;

            r6_tf   <= r5_tf;
            r6_temp <= r5_temp;
            r6_x    <= r5_x;
            r6_y    <= asr32((asr32(r5_y, 10) + 32'd2097152) * h2 + 32'd8192, 14);
            r6_v2   <= r5_v2;
            r6_v1   <= asr64(r5_sqp3, 8) + (r5_v1p2 << 12);
            r6_rp   <= r5_rp;

            r7_tf   <= r6_tf;
            r7_temp <= r6_temp;
            r7_v    <= r6_x * r6_y;
            r7_v2   <= r6_v2;
            r7_v1p1 <= ((64'd1 << 47) + r6_v1) * p1;
            r7_rp   <= r6_rp;

            r8_tf   <= r7_tf;
            r8_temp <= r7_temp;
            r8_v    <= r7_v;
            r8_ss   <= n8_h;
            r8_den  <= asr64(r7_v1p1, 33);
            r8_numa <= ((64'd1048576 - {44'd0, r7_rp}) << 31) - r7_v2;

            r9_tf   <= r8_tf;
            r9_temp <= r8_temp;
            if (n9_v[31]) begin
                r9_hum <= '0;
            end else if (n9_v > 32'd419430400) begin
                r9_hum <= 17'(32'd419430400 >> 12);
            end else begin
                r9_hum <= n9_v[28:12];
            end
            r9_den  <= r8_den;
            r9_num  <= r8_numa * 64'd3125;
        end
    end

    assign o_valid        = r_vld[Stages-1];
    assign o_side.temp    = signed'(r9_temp);
    assign o_side.fine    = signed'(r9_tf);
    assign o_side.hum     = r9_hum;
    assign o_side.zero_div = (r9_den == '0);
    assign o_num          = r9_num;
    assign o_den          = r9_den;
endmodule

/* hdl/esc_div.sv */
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// Depends on esc_pkg. Carries the sideband beside the quotient.
module esc_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [63:0]           i_num,
    input  logic [63:0]           i_den,
    input  esc_pkg::t_side        i_side,
    output logic                  o_valid,
    output logic [63:0]           o_quot,
    output esc_pkg::t_side        o_side
);
    import esc_pkg::*;

    localparam int unsigned N = DivSteps;

    logic [N:0]    r_vld;
    logic [63:0]   r_q   [N+1];
    logic [63:0]   r_rem [N+1];
    logic [63:0]   r_d   [N+1];
    logic          r_neg [N+1];
    t_side         r_sd  [N+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0]   <= i_num[63] ? 64'd0 - i_num : i_num;
            r_d[0]   <= i_den[63] ? 64'd0 - i_den : i_den;
            r_rem[0] <= '0;
            r_neg[0] <= i_num[63] ^ i_den[63];
            r_sd[0]  <= i_side;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_step
        logic [64:0] w_tr;
        logic [64:0] w_df;
        assign w_tr = {r_rem[g], r_q[g][63]};
        assign w_df = w_tr - {1'b0, r_d[g]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= w_df[64] ? w_tr[63:0] : w_df[63:0];
                r_q[g+1]   <= {r_q[g][62:0], ~w_df[64]};
                r_d[g+1]   <= r_d[g];
                r_neg[g+1] <= r_neg[g];
                r_sd[g+1]  <= r_sd[g];
            end
        end
    end

    assign o_valid = r_vld[N];
    assign o_quot  = r_neg[N] ? 64'd0 - r_q[N] : r_q[N];
    assign o_side  = r_sd[N];
endmodule

/* hdl/env_sensor_compensation.sv */
// Top level of the environmental sensor compensation pipeline.
// Instantiates esc_regs, esc_front and esc_div; uses esc_pkg.
//
//  channel | direction | tdata / fields
//  s_axis  | in        | raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
//  m_axis  | out       | temperature[31:0], fine[63:32], pressure[95:64], humidity[112:96]
//          |           | tuser = pressure_invalid
//  apb     | cfg       | six trim registers at 8*i
//
// One item enters per cycle unless the output stalls; there are 9 front stages,
// 65 divider stages and 5 tail stages including the output register. The 64-step divider
// pipeline sets the depth. Reset clears all valid bits and the trim registers.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
module env_sensor_compensation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [55:0]                   s_axis_tdata,   // raw_temperature, raw_pressure, raw_humidity
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [119:0]                  m_axis_tdata,   // temperature, fine, pressure, humidity, pad
    output logic                          m_axis_tuser,   // pressure_invalid
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [esc_pkg::AddrWidth-1:0] paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);
    import esc_pkg::*;

    t_trim       w_trim;
    logic        w_en;
    logic        w_fv, w_dv;
    t_side       w_fside, w_dside;
    logic [63:0] w_num, w_den, w_quot;
    logic signed [15:0] p7, p8, p9;

    // Tail stages.
    logic [4:0]  r_tv;
    logic [63:0] r_a_p, r_a_ps;
    t_side       r_a_sd, r_b_sd, r_c_sd, r_d_sd, r_o_sd;
    logic [63:0] r_b_p, r_b_ps, r_b_w1m, r_b_w2m;
    logic [63:0] r_c_ll, r_c_p;
    logic [31:0] r_c_lh, r_c_hl;
    logic [63:0] r_d_w1, r_d_p;
    logic [31:0] r_o_pres;

    logic [63:0] w_ll;
    logic [31:0] w_lh, w_hl;

    assign w_en          = m_axis_tready || !r_tv[4];
    assign s_axis_tready = w_en;

    assign w_ll = r_b_w1m[31:0] * r_b_ps[31:0];
    assign w_lh = r_b_w1m[31:0] * r_b_ps[63:32];
    assign w_hl = r_b_w1m[63:32] * r_b_ps[31:0];

    esc_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_trim(w_trim)
    );

    esc_front u_front (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid(s_axis_tvalid),
        .i_raw_t(s_axis_tdata[19:0]),
        .i_raw_p(s_axis_tdata[39:20]),
        .i_raw_h(s_axis_tdata[55:40]),
        .i_trim(w_trim),
        .o_valid(w_fv), .o_side(w_fside), .o_num(w_num), .o_den(w_den),
        .o_p9(p9), .o_p8(p8), .o_p7(p7)
    );

    esc_div u_div (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_fv),
        .i_num(w_num), .i_den(w_den), .i_side(w_fside),
        .o_valid(w_dv), .o_quot(w_quot), .o_side(w_dside)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= '0;
        end else if (w_en) begin
            r_tv <= {r_tv[3:0], w_dv};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_p   <= w_quot;
            r_a_ps  <= asr64(w_quot, 13);
            r_a_sd  <= w_dside;

            r_b_p   <= r_a_p;
            r_b_ps  <= r_a_ps;
            r_b_w1m <= signed'(r_a_ps) * p9;
            r_b_w2m <= signed'(r_a_p) * p8;
            r_b_sd  <= r_a_sd;

            r_c_ll  <= w_ll;
            r_c_lh  <= w_lh;
            r_c_hl  <= w_hl;
            r_c_p   <= r_b_p + asr64(r_b_w2m, 19);
            r_c_sd  <= r_b_sd;

            r_d_w1  <= asr64(r_c_ll + {r_c_lh + r_c_hl, 32'd0}, 25);
            r_d_p   <= r_c_p;
            r_d_sd  <= r_c_sd;

            r_o_pres <= r_d_sd.zero_div ? 32'd0
                      : 32'(asr64(r_d_p + r_d_w1, 8) + (64'(p7) << 4));
            r_o_sd   <= r_d_sd;
        end
    end

    assign m_axis_tvalid = r_tv[4];
    assign m_axis_tdata  = {7'd0, r_o_sd.hum, r_o_pres, r_o_sd.fine, r_o_sd.temp};
    assign m_axis_tuser  = r_o_sd.zero_div;

    no_loss_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped");
    hum_range_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[112:96] <= 17'd102400)
        else $error("humidity out of range");
    inval_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[95:64] == 32'd0)
        else $error("invalid pressure nonzero");
endmodule
